// ----- rtl/dmg_pkg.sv -----
package dmg_pkg;

    // Quotient width and saturation level of the gray output
    localparam int GRAY_W    = 8;
    localparam int DIV_STEPS = GRAY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};

    // Depth sample width (signed Q16.16)
    localparam int DEPTH_W = 32;

    typedef struct packed {
        logic                      mode;
        logic signed [DEPTH_W-1:0] depth;
        logic                      depth_valid;
        logic                      first_of_frame;
    } t_in;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              range_known;
    } t_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic measure;
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage

// ----- rtl/dmg_datapath.sv -----
module dmg_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmg_pkg::t_in        i_in_data,
    input  dmg_pkg::t_dp_cmd    i_cmd,
    output dmg_pkg::t_dp_status o_status,
    output dmg_pkg::t_out       o_out_data
);
    import dmg_pkg::*;

    // Range state
    logic signed [DEPTH_W-1:0] r_low, n_low;
    logic signed [DEPTH_W-1:0] r_high, n_high;
    logic                      r_found, n_found;

    // Divider state
    logic [DEPTH_W-1:0] r_rem;
    logic [DEPTH_W-1:0] r_span;
    logic [GRAY_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_zero;
    logic               r_sat;
    logic               r_known;

    // Output payload
    t_out r_out;

    logic               found_eff;
    logic signed [DEPTH_W:0] diff;
    logic signed [DEPTH_W:0] span;
    logic [DEPTH_W:0]   rem2;
    logic               fits;
    logic [GRAY_W-1:0]  gray_res;

    // Update the running range in the measure pass
    assign found_eff = r_found & ~i_in_data.first_of_frame;

    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_found = r_found;
        if (i_cmd.measure) begin
            n_found = found_eff;
            if (i_in_data.depth_valid) begin
                n_found = 1'b1;
                if (!found_eff) begin
                    n_low  = i_in_data.depth;
                    n_high = i_in_data.depth;
                end else begin
                    if (i_in_data.depth > r_high) n_high = i_in_data.depth;
                    if (i_in_data.depth < r_low)  n_low  = i_in_data.depth;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_found <= 1'b0;
        end else begin
            r_low   <= n_low;
            r_high  <= n_high;
            r_found <= n_found;
        end
    end

    // Offset of the sample and width of the range
    assign diff = {i_in_data.depth[DEPTH_W-1], i_in_data.depth} - {r_low[DEPTH_W-1], r_low};
    assign span = {r_high[DEPTH_W-1], r_high} - {r_low[DEPTH_W-1], r_low};

    // One restoring division step
    assign rem2 = {r_rem, 1'b0};
    assign fits = (rem2 >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= diff[DEPTH_W-1:0];
            r_span  <= span[DEPTH_W-1:0];
            r_quo   <= '0;
            r_zero  <= ~i_in_data.depth_valid | ~r_found | (span <= 0) | (diff <= 0);
            r_sat   <= (diff >= span);
            r_known <= r_found;
        end else if (i_cmd.step) begin
            r_rem <= fits ? DEPTH_W'(rem2 - {1'b0, r_span}) : rem2[DEPTH_W-1:0];
            r_quo <= {r_quo[GRAY_W-2:0], fits};
        end
    end

    // Count divide steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    // Select zero, saturation or quotient and hold it for the output
    assign gray_res = r_zero ? '0 : (r_sat ? GRAY_MAX : r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.gray        <= gray_res;
            r_out.range_known <= r_known;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- rtl/dmg_ctrl.sv -----
module dmg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dmg_pkg::t_dp_status i_status,
    output dmg_pkg::t_dp_cmd    o_cmd
);
    import dmg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   emit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign emit       = (r_state == ST_DONE) & (~r_out_valid | i_out_ready);

    // Drive datapath commands
    assign o_cmd.measure = accept & ~i_mode;
    assign o_cmd.load    = accept & i_mode;
    assign o_cmd.step    = (r_state == ST_DIV);
    assign o_cmd.emit    = emit;

    // Advance through load, divide and result hand-off
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_mode) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the result until the consumer takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/depth_minmax_to_gray_unit.sv -----
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_in_data  (mode, depth, depth_valid, first_of_frame)
// output    o_out_valid / i_out_ready    o_out_data (gray, range_known)
//
// A measure transaction updates the range at acceptance.
// A map transaction runs through acceptance, 8 steps of the restoring divider
// (one quotient bit per cycle), and a load into the output register.
// Reset (synchronous, active low) clears the range and the control state.
// A result waiting in the output register does not block new input; a finished
// quotient waits in the divider until the output register is free.
module depth_minmax_to_gray_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dmg_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dmg_pkg::t_out o_out_data
);
    import dmg_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    dmg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_in_data.mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dmg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule
